/* hdl/rtm_pkg.sv */
// ----------------------------------------------------------------------------
// rtm_pkg: shared constants, types and tables of the Reinhard/sRGB encoder
// Fixed-point formats, pipeline depths and the sRGB byte threshold table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtm_pkg;

  // input format
  localparam int IN_FRAC_BITS = 16;
  localparam int IN_INT_BITS  = 16;
  localparam int IN_W         = IN_INT_BITS + IN_FRAC_BITS;
  localparam int PIX_W        = 32;
  localparam int BYTE_W       = 8;
  localparam int USE_W        = (IN_W < PIX_W) ? IN_W : PIX_W;
  localparam int HDR_MAX      = 65504;
  // wide enough for both the masked input and the saturation cap
  localparam int RAW_W        = (IN_W > 16 + IN_FRAC_BITS) ? IN_W : 16 + IN_FRAC_BITS;

  // Reinhard quotient, Q0.24
  localparam int M_W     = 24;
  localparam int DIV_LAT = M_W + 1;

  // encoder
  localparam int                SRCH_STEPS = 8;
  localparam int                ENC_LAT    = SRCH_STEPS + 1;
  localparam int                LIN_W      = 16;
  localparam logic [M_W-1:0]    KNEE_Q24   = 24'd52526;
  localparam logic [16:0]       LIN_MUL    = 17'd32946;
  localparam logic [32:0]       LIN_BIAS   = 33'd5 << 24;
  localparam logic [7:0]        DIV10_MUL  = 8'd205;
  localparam logic [BYTE_W-1:0] ALPHA_OUT  = 8'hFF;

  // divider stage contents
  typedef struct packed {
    logic [RAW_W+1:0] rem;
    logic [RAW_W:0]   den;
    logic [M_W-1:0]   q;
  } div_stage_t;

  // search stage contents
  typedef struct packed {
    logic [M_W-1:0]    m;
    logic [BYTE_W-1:0] idx;
    logic              lin;
    logic [BYTE_W-1:0] lin_byte;
  } srch_stage_t;

  // smallest M that encodes to at least byte k on the power segment:
  // M^5 * 10761^12 >= (40k+541)^12 * 2^120
  typedef logic [M_W:0] thr_t;
  typedef thr_t thr_arr_t [256];

  function automatic thr_arr_t build_thresh();
    thr_arr_t     t;
    logic [319:0] a;
    logic [319:0] b;
    logic [319:0] p;
    logic [M_W+1:0] lo;
    logic [M_W+1:0] hi;
    logic [M_W+1:0] mid;
    int k;
    int i;
    int j;
    a = 320'd1;
    for (i = 0; i < 12; i++) a = a * 320'd10761;
    t[0] = '0;
    for (k = 1; k < 256; k++) begin
      b = 320'd1;
      for (i = 0; i < 12; i++) b = b * 320'(40 * k + 541);
      b  = b << 120;
      lo = '0;
      hi = (M_W+2)'(1) << M_W;
      for (i = 0; i < M_W + 2; i++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          p   = a;
          for (j = 0; j < 5; j++) p = p * 320'(mid);
          if (p >= b) hi = mid;
          else        lo = mid + 1'b1;
        end
      end
      t[k] = hi[M_W:0];
    end
    return t;
  endfunction

  localparam thr_arr_t THRESH = build_thresh();

endpackage

`default_nettype wire

/* hdl/rtm_pix_if.sv */
// ----------------------------------------------------------------------------
// rtm_pix_if: linear HDR pixel channel
// Valid/ready channel carrying three linear fixed-point color channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtm_pix_if import rtm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] lin_red;
  logic [PIX_W-1:0] lin_green;
  logic [PIX_W-1:0] lin_blue;

  modport source (output valid, output lin_red, output lin_green, output lin_blue,
                  input ready);
  modport sink   (input valid, input lin_red, input lin_green, input lin_blue,
                  output ready);
endinterface

`default_nettype wire

/* hdl/rtm_srgb_if.sv */
// ----------------------------------------------------------------------------
// rtm_srgb_if: encoded sRGBA pixel channel
// Valid/ready channel carrying three 8-bit color bytes and an 8-bit alpha byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtm_srgb_if import rtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] srgb_red;
  logic [BYTE_W-1:0] srgb_green;
  logic [BYTE_W-1:0] srgb_blue;
  logic [BYTE_W-1:0] alpha_out;

  modport source (output valid, output srgb_red, output srgb_green, output srgb_blue,
                  output alpha_out, input ready);
  modport sink   (input valid, input srgb_red, input srgb_green, input srgb_blue,
                  input alpha_out, output ready);
endinterface

`default_nettype wire

/* hdl/rtm_div.sv */
// ----------------------------------------------------------------------------
// rtm_div: per-channel saturation and Reinhard divider
// Computes M = floor(c * 2^24 / (c + 1)) with a restoring divider, one
// quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rtm_div import rtm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [PIX_W-1:0] raw_i,
  output logic      [M_W-1:0]   m_o
);

  localparam logic [RAW_W-1:0] CAP = RAW_W'(HDR_MAX) << IN_FRAC_BITS;
  localparam logic [RAW_W:0]   ONE = (RAW_W+1)'(1) << IN_FRAC_BITS;

  div_stage_t st_q [M_W+1];
  div_stage_t st_d [M_W+1];
  logic [RAW_W-1:0] raw;
  logic [RAW_W-1:0] sat;

  // saturate and set up the divide
  always_comb begin
    raw          = RAW_W'(raw_i[USE_W-1:0]);
    sat          = (raw > CAP) ? CAP : raw;
    st_d[0].rem  = {2'b00, sat};
    st_d[0].den  = {1'b0, sat} + ONE;
    st_d[0].q    = '0;
  end

  // one quotient bit per stage; remainder always stays below the divisor
  for (genvar s = 1; s <= M_W; s++) begin : g_step
    logic [RAW_W+1:0] sh;
    logic             ge;
    always_comb begin
      sh          = {st_q[s-1].rem[RAW_W:0], 1'b0};
      ge          = (sh >= {1'b0, st_q[s-1].den});
      st_d[s].rem = ge ? (sh - {1'b0, st_q[s-1].den}) : sh;
      st_d[s].den = st_q[s-1].den;
      st_d[s].q   = {st_q[s-1].q[M_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s <= M_W; s++) st_q[s] <= st_d[s];
    end
  end

  assign m_o = st_q[M_W].q;

endmodule

`default_nettype wire

/* hdl/rtm_enc.sv */
// ----------------------------------------------------------------------------
// rtm_enc: sRGB transfer curve and byte quantizer
// Linear segment by multiply and divide-by-ten; power segment by a pipelined
// binary search over the constant threshold table.
// ----------------------------------------------------------------------------
`default_nettype none

module rtm_enc import rtm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [M_W-1:0]    m_i,
  output logic      [BYTE_W-1:0] byte_o
);

  logic [M_W-1:0] m_q;
  logic           lin_q;
  logic [32:0]    prod_q;
  logic [32:0]    prod_d;

  srch_stage_t sr_q [1:SRCH_STEPS];
  srch_stage_t sr_d [1:SRCH_STEPS];

  logic [8:0]  lin_v;
  logic [16:0] lin_div;

  // front stage: linear-segment product
  assign prod_d = 33'(LIN_MUL) * 33'(m_i[LIN_W-1:0]) + LIN_BIAS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_i;
      lin_q  <= (m_i <= KNEE_Q24);
      prod_q <= prod_d;
    end
  end

  // x / 10 for small x via reciprocal 205/2048
  assign lin_v   = prod_q[32:24];
  assign lin_div = 17'(lin_v) * 17'(DIV10_MUL);

  // binary search, one byte bit per stage, MSB first
  for (genvar s = 1; s <= SRCH_STEPS; s++) begin : g_srch
    srch_stage_t       prev;
    logic [BYTE_W-1:0] cand;
    always_comb begin
      if (s == 1) begin
        prev.m        = m_q;
        prev.idx      = '0;
        prev.lin      = lin_q;
        prev.lin_byte = BYTE_W'(lin_div[16:11]);
      end else begin
        prev = sr_q[(s > 1) ? s-1 : 1];
      end
      cand            = prev.idx | (BYTE_W'(1) << (SRCH_STEPS - s));
      sr_d[s]         = prev;
      if ({1'b0, prev.m} >= THRESH[cand]) sr_d[s].idx = cand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 1; s <= SRCH_STEPS; s++) sr_q[s] <= sr_d[s];
    end
  end

  assign byte_o = sr_q[SRCH_STEPS].lin ? sr_q[SRCH_STEPS].lin_byte
                                       : sr_q[SRCH_STEPS].idx;

endmodule

`default_nettype wire

/* hdl/reinhard_tonemap_srgb8.sv */
// ----------------------------------------------------------------------------
// reinhard_tonemap_srgb8: Reinhard tone map with 8-bit sRGB encoding
// Three channel lanes, each a divider and an encoder, merged into one beat.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one linear HDR pixel per beat (three unsigned fixed-point
//   channels); srgb_o returns one sRGBA beat per pixel, in order, with alpha
//   fixed at 255.
//   Throughput: one pixel per cycle while the output is not stalled. Each
//   lane is a fully pipelined restoring divider (one quotient bit per
//   stage) followed by the encoder. From the input beat to a valid output
//   beat, a pixel passes the divider, encoder and output registers in turn.
//   All stages advance together whenever the output register is empty or
//   being taken; when the receiver stalls with a beat pending, the whole
//   pipeline holds and pix_i.ready drops.
//   Reset clears the stage valid bits and the output valid; no clearing
//   pass, the block accepts beats right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module reinhard_tonemap_srgb8 import rtm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rtm_pix_if.sink     pix_i,
  rtm_srgb_if.source  srgb_o
);

  localparam int PIPE_LAT = DIV_LAT + ENC_LAT;

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;
  logic                out_vld_q;
  logic [PIX_W-1:0]    raw   [3];
  logic [M_W-1:0]      m     [3];
  logic [BYTE_W-1:0]   bytes [3];
  logic [BYTE_W-1:0]   out_q [3];

  // pipeline advance
  assign en          = !out_vld_q || srgb_o.ready;
  assign pix_i.ready = en;

  assign raw[0] = pix_i.lin_red;
  assign raw[1] = pix_i.lin_green;
  assign raw[2] = pix_i.lin_blue;

  // channel lanes
  for (genvar l = 0; l < 3; l++) begin : g_lane
    rtm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .raw_i (raw[l]),
      .m_o   (m[l])
    );
    rtm_enc u_enc (
      .clk_i  (clk_i),
      .en_i   (en),
      .m_i    (m[l]),
      .byte_o (bytes[l])
    );
  end

  // beat tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE_LAT-2:0], pix_i.valid};
      out_vld_q <= vld_q[PIPE_LAT-1];
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) out_q[l] <= bytes[l];
    end
  end

  assign srgb_o.valid      = out_vld_q;
  assign srgb_o.srgb_red   = out_q[0];
  assign srgb_o.srgb_green = out_q[1];
  assign srgb_o.srgb_blue  = out_q[2];
  assign srgb_o.alpha_out  = ALPHA_OUT;

endmodule

`default_nettype wire
